### hw/rtl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// shared widths and defaults for the rtime block decompressor
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam int BLOCK_MAX_DEF = 4096;
   localparam int BLEN_W        = 13;
   localparam int BYTE_W        = 8;
   localparam int REP_W         = 8;
   localparam int WORD_W        = 32;
   localparam int CNT_W         = 3;
   localparam int WORD_BYTES    = 4;
   localparam int SYM_COUNT     = 256;
   localparam int SYM_W         = 8;

endpackage

### hw/rtl/rbd_if.sv
// ----------------------------------------------------------------------------
// rbd channel interfaces
// valid/ready channels for source pairs and packed output words
// ----------------------------------------------------------------------------
interface rbd_req_if;
   logic                        valid;
   logic                        ready;
   logic                        first_of_block;
   logic [rbd_pkg::BLEN_W-1:0]  block_length;
   logic [rbd_pkg::BYTE_W-1:0]  literal_byte;
   logic [rbd_pkg::REP_W-1:0]   repeat_count;
   logic                        last_of_source;

   modport source (
      output valid, first_of_block, block_length, literal_byte, repeat_count,
             last_of_source,
      input  ready
   );
   modport sink (
      input  valid, first_of_block, block_length, literal_byte, repeat_count,
             last_of_source,
      output ready
   );
endinterface

interface rbd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rbd_pkg::WORD_W-1:0]  out_bytes;
   logic [rbd_pkg::CNT_W-1:0]   byte_count;
   logic                        run_last;
   logic                        block_done;
   logic                        status;

   modport source (
      output valid, out_bytes, byte_count, run_last, block_done, status,
      input  ready
   );
   modport sink (
      input  valid, out_bytes, byte_count, run_last, block_done, status,
      output ready
   );
endinterface

### hw/rtl/rbd_ram.sv
// ----------------------------------------------------------------------------
// rbd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rtime_block_decompressor_top.sv
// ----------------------------------------------------------------------------
// rtime_block_decompressor_top
// rtime block decompressor: literal/repeat pairs in, packed byte words out
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one source pair per word; first_of_block starts a new
//   block and latches block_length (saturated to BLOCK_MAX). rsp_chan returns
//   up to four output bytes per word, earliest byte in bits 7:0, with
//   run_last on the final word of a pair and block_done when the block is
//   complete. Malformed input gives one word with status 1 and byte_count 0.
//   Pairs arriving with no active block are dropped silently.
//   Sequence: an accepted pair is checked in ST_CHECK, where an error or
//   empty-block word is registered; a good pair writes its literal, reads the
//   position table in ST_LOOKUP and copies its repeat bytes in ST_COPY,
//   one history byte per cycle while the output register has room, set by
//   the single read port of the history memory.
//   req_chan.ready is high only between pairs.
//   Reset clears the sequencer, the output register, the block state and the
//   position table valid bits; no clearing pass is needed.
//   When rsp_chan stalls, the sequencer holds in place and resumes when the
//   output register empties; no word is dropped.
// ----------------------------------------------------------------------------
module rtime_block_decompressor_top #(
   parameter int BLOCK_MAX = rbd_pkg::BLOCK_MAX_DEF
) (
   input  logic         clock,
   input  logic         reset,
   rbd_req_if.sink      req_chan,
   rbd_rsp_if.source    rsp_chan
);

   import rbd_pkg::*;

   localparam int PW = $clog2(BLOCK_MAX + 1);
   localparam int AW = $clog2(BLOCK_MAX);
   localparam int LW = (PW > BLEN_W) ? PW : BLEN_W;
   localparam int EW = ((PW > REP_W) ? PW : REP_W) + 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;
   localparam logic [1:0] ST_COPY   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic                  first_ff, first_in;
   logic [BLEN_W-1:0]     blen_ff, blen_in;
   logic [SYM_W-1:0]      lit_ff, lit_in;
   logic [REP_W-1:0]      rep_ff, rep_in;
   logic                  srcend_ff, srcend_in;

   logic                  active_ff, active_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [PW-1:0]         len_ff, len_in;
   logic [PW-1:0]         wr_ff, wr_in;
   logic [PW-1:0]         src_ff, src_in;
   logic [REP_W-1:0]      rem_ff, rem_in;
   logic [WORD_W-1:0]     pack_ff, pack_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SYM_COUNT-1:0]  valid_ff, valid_in;
   logic                  fwd_ff, fwd_in;
   logic [BYTE_W-1:0]     fwd_data_ff, fwd_data_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_bytes_ff, rsp_bytes_in;
   logic [CNT_W-1:0]      rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_done_ff, rsp_done_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic                  hist_we, hist_re;
   logic [AW-1:0]         hist_waddr, hist_raddr;
   logic [BYTE_W-1:0]     hist_wdata, hist_q;
   logic                  tab_we, tab_re;
   logic [PW-1:0]         tab_q;

   logic                  slot;
   logic                  emit;
   logic [LW-1:0]         blen_ext;
   logic [PW-1:0]         len_sat;
   logic [PW-1:0]         pos_eff;
   logic [PW-1:0]         len_eff;
   logic                  act_eff;
   logic [EW-1:0]         endpos;
   logic                  bad_pair;
   logic [PW-1:0]         src;
   logic [BYTE_W-1:0]     copy_byte;
   logic [WORD_W-1:0]     pack_new;
   logic [CNT_W-1:0]      cnt_new;
   logic                  copy_last;
   logic                  copy_done;

   rbd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BLOCK_MAX)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_en   (hist_re),
      .rd_addr (hist_raddr),
      .rd_data (hist_q)
   );

   rbd_ram #(
      .WIDTH (PW),
      .DEPTH (SYM_COUNT)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (lit_ff),
      .wr_data (wr_ff),
      .rd_en   (tab_re),
      .rd_addr (lit_ff),
      .rd_data (tab_q)
   );

   assign slot            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready  = (state_ff == ST_IDLE);

   // block length saturation, overrun and early end-of-source check
   assign blen_ext = LW'(blen_ff);
   assign len_sat  = (blen_ext > LW'(BLOCK_MAX)) ? PW'(BLOCK_MAX) : blen_ext[PW-1:0];
   assign pos_eff  = first_ff ? '0 : pos_ff;
   assign len_eff  = first_ff ? len_sat : len_ff;
   assign act_eff  = first_ff || active_ff;
   assign endpos   = EW'(pos_eff) + EW'(rep_ff) + EW'(1);
   assign bad_pair = (endpos > EW'(len_eff)) || (srcend_ff && (endpos < EW'(len_eff)));

   // copy datapath
   assign src       = valid_ff[lit_ff] ? tab_q : '0;
   assign copy_byte = fwd_ff ? fwd_data_ff : hist_q;
   assign pack_new  = pack_ff | (WORD_W'(copy_byte) << {cnt_ff[1:0], 3'b000});
   assign cnt_new   = cnt_ff + CNT_W'(1);
   assign copy_last = (rem_ff == REP_W'(1));
   assign copy_done = copy_last && ((wr_ff + PW'(1)) == len_ff);

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      blen_in       = blen_ff;
      lit_in        = lit_ff;
      rep_in        = rep_ff;
      srcend_in     = srcend_ff;
      active_in     = active_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      wr_in         = wr_ff;
      src_in        = src_ff;
      rem_in        = rem_ff;
      pack_in       = pack_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      fwd_in        = fwd_ff;
      fwd_data_in   = fwd_data_ff;
      hist_we       = 1'b0;
      hist_re       = 1'b0;
      hist_waddr    = '0;
      hist_raddr    = '0;
      hist_wdata    = '0;
      tab_we        = 1'b0;
      tab_re        = 1'b0;
      emit          = 1'b0;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               first_in  = req_chan.first_of_block;
               blen_in   = req_chan.block_length;
               lit_in    = req_chan.literal_byte;
               rep_in    = req_chan.repeat_count;
               srcend_in = req_chan.last_of_source;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (slot) begin
               state_in = ST_IDLE;
               if (first_ff) begin
                  pos_in    = '0;
                  len_in    = len_sat;
                  valid_in  = '0;
                  active_in = 1'b1;
               end
               if (first_ff && (len_sat == '0)) begin
                  // empty block completes at once
                  emit          = 1'b1;
                  rsp_bytes_in  = '0;
                  rsp_cnt_in    = '0;
                  rsp_last_in   = 1'b1;
                  rsp_done_in   = 1'b1;
                  rsp_status_in = 1'b0;
                  active_in     = 1'b0;
               end else if (!act_eff) begin
                  state_in = ST_IDLE;
               end else if (bad_pair) begin
                  emit          = 1'b1;
                  rsp_bytes_in  = '0;
                  rsp_cnt_in    = '0;
                  rsp_last_in   = 1'b1;
                  rsp_done_in   = 1'b0;
                  rsp_status_in = 1'b1;
                  active_in     = 1'b0;
               end else begin
                  hist_we    = 1'b1;
                  hist_waddr = pos_eff[AW-1:0];
                  hist_wdata = lit_ff;
                  tab_re     = 1'b1;
                  pack_in    = WORD_W'(lit_ff);
                  cnt_in     = CNT_W'(1);
                  wr_in      = pos_eff + PW'(1);
                  rem_in     = rep_ff;
                  state_in   = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (slot) begin
               tab_we           = 1'b1;
               valid_in[lit_ff] = 1'b1;
               hist_re          = 1'b1;
               hist_raddr       = src[AW-1:0];
               src_in           = src + PW'(1);
               if (rep_ff == '0) begin
                  emit          = 1'b1;
                  rsp_bytes_in  = pack_ff;
                  rsp_cnt_in    = cnt_ff;
                  rsp_last_in   = 1'b1;
                  rsp_done_in   = (wr_ff == len_ff);
                  rsp_status_in = 1'b0;
                  pack_in       = '0;
                  cnt_in        = '0;
                  pos_in        = wr_ff;
                  if (wr_ff == len_ff) begin
                     active_in = 1'b0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            if (slot) begin
               hist_we    = 1'b1;
               hist_waddr = wr_ff[AW-1:0];
               hist_wdata = copy_byte;
               hist_re    = 1'b1;
               hist_raddr = src_ff[AW-1:0];
               src_in     = src_ff + PW'(1);
               wr_in      = wr_ff + PW'(1);
               rem_in     = rem_ff - REP_W'(1);
               if (copy_last || (cnt_new == CNT_W'(WORD_BYTES))) begin
                  emit          = 1'b1;
                  rsp_bytes_in  = pack_new;
                  rsp_cnt_in    = cnt_new;
                  rsp_last_in   = copy_last;
                  rsp_done_in   = copy_done;
                  rsp_status_in = 1'b0;
                  pack_in       = '0;
                  cnt_in        = '0;
               end else begin
                  pack_in = pack_new;
                  cnt_in  = cnt_new;
               end
               if (copy_last) begin
                  pos_in   = wr_ff + PW'(1);
                  state_in = ST_IDLE;
                  if (copy_done) begin
                     active_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // read that lands on the address written in the same cycle
      if (hist_re) begin
         fwd_in      = hist_we && (hist_raddr == hist_waddr);
         fwd_data_in = hist_wdata;
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         len_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         cnt_ff       <= '0;
         pack_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
         cnt_ff       <= cnt_in;
         pack_ff      <= pack_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff      <= first_in;
      blen_ff       <= blen_in;
      lit_ff        <= lit_in;
      rep_ff        <= rep_in;
      srcend_ff     <= srcend_in;
      wr_ff         <= wr_in;
      src_ff        <= src_in;
      rem_ff        <= rem_in;
      fwd_data_ff   <= fwd_data_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_bytes  = rsp_bytes_ff;
   assign rsp_chan.byte_count = rsp_cnt_ff;
   assign rsp_chan.run_last   = rsp_last_ff;
   assign rsp_chan.block_done = rsp_done_ff;
   assign rsp_chan.status     = rsp_status_ff;

   // copy source never runs ahead of the write pointer
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (src_ff <= wr_ff))
      else $error("copy source ahead of write pointer");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (rem_ff != '0))
      else $error("copy state with no bytes left");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff || rsp_done_ff)) |-> rsp_last_ff)
      else $error("error or done word not last of run");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> ((rsp_cnt_ff == '0) && !rsp_done_ff))
      else $error("error word carries bytes");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (pos_ff <= len_ff))
      else $error("output position beyond block length");

endmodule
